>>> rtl/core/rhht_pkg.sv
package rhht_pkg;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_FIND   = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   localparam int unsigned KEY_W     = 64;
   localparam int unsigned HASH_W    = 32;
   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned SLOT_W    = 10;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned FILL_W    = 10;
   localparam logic [FILL_W-1:0] FILL_RESET = 10'd512;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ,
      CMD_WRITE_CARRY,
      CMD_WRITE_VALUE,
      CMD_CLEAR,
      CMD_SHIFT_BACK,
      CMD_VACATE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       advance;
   } dp_cmd_type;

   typedef struct packed {
      logic taken;
      logic key_match;
      logic dist_less;
      logic dist_zero;
      logic bound_hit;
      logic full;
      logic clearing;
   } dp_status_type;

endpackage

>>> rtl/core/rhht_req_if.sv
interface rhht_req_if;
   import rhht_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [KEY_W-1:0]    key;
   logic [HASH_W-1:0]   key_hash;
   logic [VALUE_W-1:0]  value;
   modport source (output valid, req_type, key, key_hash, value, input ready);
   modport sink   (input valid, req_type, key, key_hash, value, output ready);
endinterface

>>> rtl/core/rhht_rsp_if.sv
interface rhht_rsp_if;
   import rhht_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [VALUE_W-1:0]  value_out;
   logic [COUNT_W-1:0]  entry_count;
   modport source (output valid, status, slot, value_out, entry_count, input ready);
   modport sink   (input valid, status, slot, value_out, entry_count, output ready);
endinterface

>>> rtl/core/rhht_datapath.sv
module rhht_datapath
   import rhht_pkg::*;
#(
   parameter int unsigned CAPACITY   = 1024,
   parameter int unsigned KEY_BITS   = 64,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [HASH_W-1:0]     req_hash,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [FILL_W-1:0]     max_fill,
   output dp_status_type         stat,
   output logic [SLOT_W-1:0]     landed_slot,
   output logic [VALUE_W-1:0]    read_value,
   output logic [COUNT_W-1:0]    fill_count
);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned DIS_W = $clog2(CAPACITY) + 1;
   localparam int unsigned FC_W  = $clog2(CAPACITY) + 1;
   localparam int unsigned ENT_W = 1 + KEY_BITS + VALUE_BITS + DIS_W;

   logic [ENT_W-1:0]      mem [CAPACITY];

   logic [IDX_W-1:0]      pos_ff, pos_in, nxt_pos;
   logic [IDX_W-1:0]      prev_ff;
   logic [IDX_W-1:0]      clr_ff;
   logic                  clearing_ff;
   logic [DIS_W-1:0]      dist_ff, dist_in;
   logic [DIS_W-1:0]      steps_ff, steps_in;
   logic [KEY_BITS-1:0]   ckey_ff, ckey_in;
   logic [VALUE_BITS-1:0] cval_ff, cval_in;
   logic [FC_W-1:0]       fill_ff;
   logic [IDX_W-1:0]      land_ff;
   logic                  have_ff;
   logic [ENT_W-1:0]      rd_ff;
   logic                  rd_taken;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [DIS_W-1:0]      rd_dist;
   logic [IDX_W-1:0]      home;

   assign {rd_taken, rd_key, rd_val, rd_dist} = rd_ff;
   assign home    = IDX_W'(req_hash % CAPACITY);
   assign nxt_pos = (32'(pos_ff) == CAPACITY - 1) ? '0 : pos_ff + 1'b1;

   always_comb begin
      pos_in   = pos_ff;
      dist_in  = dist_ff;
      steps_in = steps_ff;
      ckey_in  = ckey_ff;
      cval_in  = cval_ff;
      if (cmd.op == CMD_LOAD) begin
         pos_in   = home;
         dist_in  = '0;
         steps_in = '0;
         ckey_in  = req_key[KEY_BITS-1:0];
         cval_in  = req_value[VALUE_BITS-1:0];
      end else if (cmd.op == CMD_WRITE_CARRY && rd_taken) begin
         ckey_in = rd_key;
         cval_in = rd_val;
         dist_in = rd_dist;
      end else if (cmd.op == CMD_CLEAR) begin
         steps_in = '0;
      end
      if (cmd.advance) begin
         pos_in   = nxt_pos;
         dist_in  = dist_in + 1'b1;
         steps_in = steps_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      dist_ff  <= dist_in;
      steps_ff <= steps_in;
      ckey_ff  <= ckey_in;
      cval_ff  <= cval_in;
      if (cmd.op == CMD_READ) begin
         rd_ff <= mem[pos_ff];
      end
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else begin
         case (cmd.op)
            CMD_WRITE_CARRY: mem[pos_ff] <= {1'b1, ckey_ff, cval_ff, dist_ff};
            CMD_WRITE_VALUE: mem[pos_ff] <= {1'b1, rd_key, cval_ff, rd_dist};
            CMD_SHIFT_BACK:  mem[prev_ff] <= {1'b1, rd_key, rd_val, rd_dist - 1'b1};
            CMD_VACATE:      mem[prev_ff] <= '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         have_ff     <= 1'b0;
         land_ff     <= '0;
         prev_ff     <= '0;
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) == CAPACITY - 1) clearing_ff <= 1'b0;
         end
         case (cmd.op)
            CMD_LOAD: begin
               have_ff <= 1'b0;
               land_ff <= '0;
            end
            CMD_WRITE_CARRY: begin
               if (!have_ff) begin
                  land_ff <= pos_ff;
                  have_ff <= 1'b1;
               end
               if (!rd_taken) fill_ff <= fill_ff + 1'b1;
            end
            CMD_CLEAR: begin
               prev_ff <= pos_ff;
               if (fill_ff != '0) fill_ff <= fill_ff - 1'b1;
            end
            CMD_SHIFT_BACK: begin
               prev_ff <= pos_ff;
            end
            default: ;
         endcase
      end
   end

   assign stat.taken     = rd_taken;
   assign stat.key_match = rd_key == ckey_ff;
   assign stat.dist_less = rd_dist < dist_ff;
   assign stat.dist_zero = rd_dist == '0;
   assign stat.bound_hit = 32'(steps_ff) >= CAPACITY;
   assign stat.full      = (32'(fill_ff) >= 32'(max_fill)) || (32'(fill_ff) >= CAPACITY);
   assign stat.clearing  = clearing_ff;
   assign landed_slot    = have_ff ? SLOT_W'(32'(land_ff)) : SLOT_W'(32'(pos_ff));
   assign read_value     = VALUE_W'(rd_val);
   assign fill_count     = COUNT_W'(fill_ff);
endmodule

>>> rtl/core/rhht_controller.sv
module rhht_controller
   import rhht_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [VALUE_W-1:0]   rsp_value_out,
   output logic [COUNT_W-1:0]   rsp_entry_count,
   output dp_cmd_type           cmd,
   input  dp_status_type        stat,
   input  logic [SLOT_W-1:0]    landed_slot,
   input  logic [VALUE_W-1:0]   read_value,
   input  logic [COUNT_W-1:0]   fill_count
);
   typedef enum logic [3:0] {
      S_IDLE, S_LREAD, S_LCHECK, S_PREAD, S_PCHECK, S_RREAD, S_RCHECK, S_DONE
   } state_type;

   state_type            state_ff;
   logic [1:0]           op_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [VALUE_W-1:0]   vout_ff;

   always_comb begin
      cmd = '{op: CMD_NONE, advance: 1'b0};
      case (state_ff)
         S_IDLE:   if (req_valid && req_ready) cmd.op = CMD_LOAD;
         S_LREAD, S_PREAD, S_RREAD: cmd.op = CMD_READ;
         S_LCHECK: begin
            if (stat.taken && stat.key_match) begin
               if (op_ff == REQ_INSERT) cmd.op = CMD_WRITE_VALUE;
               else if (op_ff == REQ_REMOVE) begin
                  cmd.op = CMD_CLEAR;
                  cmd.advance = 1'b1;
               end
            end else if (stat.taken && !stat.dist_less && !stat.bound_hit)
               cmd.advance = 1'b1;
         end
         S_PCHECK: begin
            if (!stat.bound_hit && (!stat.taken || stat.dist_less)) cmd.op = CMD_WRITE_CARRY;
            if (!stat.bound_hit && stat.taken) cmd.advance = 1'b1;
         end
         S_RCHECK: begin
            if (stat.taken && !stat.dist_zero && !stat.bound_hit) begin
               cmd.op = CMD_SHIFT_BACK;
               cmd.advance = 1'b1;
            end else begin
               cmd.op = CMD_VACATE;
            end
         end
         default: ;
      endcase
   end

   assign req_ready = state_ff == S_IDLE && !rsp_valid && !stat.clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff     <= req_type;
                  status_ff <= ST_NOT_FOUND;
                  slot_ff   <= '0;
                  vout_ff   <= '0;
                  state_ff  <= (req_type == REQ_NONE) ? S_DONE : S_LREAD;
               end
            end
            S_LREAD: state_ff <= S_LCHECK;
            S_LCHECK: begin
               if (stat.taken && stat.key_match) begin
                  slot_ff <= landed_slot;
                  case (op_ff)
                     REQ_INSERT: begin
                        status_ff <= ST_UPDATED;
                        state_ff  <= S_DONE;
                     end
                     REQ_FIND: begin
                        status_ff <= ST_FOUND;
                        vout_ff   <= read_value;
                        state_ff  <= S_DONE;
                     end
                     default: begin
                        status_ff <= ST_REMOVED;
                        slot_ff   <= '0;
                        state_ff  <= S_RREAD;
                     end
                  endcase
               end else if (stat.taken && !stat.dist_less && !stat.bound_hit) begin
                  state_ff <= S_LREAD;
               end else if (op_ff == REQ_INSERT) begin
                  if (stat.full) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     status_ff <= ST_INSERTED;
                     state_ff  <= S_PREAD;
                  end
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_PREAD: state_ff <= S_PCHECK;
            S_PCHECK: begin
               slot_ff  <= landed_slot;
               state_ff <= (!stat.taken || stat.bound_hit) ? S_DONE : S_PREAD;
            end
            S_RREAD: state_ff <= S_RCHECK;
            S_RCHECK: begin
               state_ff <= (stat.taken && !stat.dist_zero && !stat.bound_hit) ? S_RREAD
                                                                              : S_DONE;
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         rsp_status      <= status_ff;
         rsp_slot        <= slot_ff;
         rsp_value_out   <= vout_ff;
         rsp_entry_count <= fill_count;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while response pending");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid)
      else $error("finished transaction not presented");
endmodule

>>> rtl/core/robin_hood_hash_table.sv
// Robin Hood hash table: open addressing with linear probing and backward-shift
// removal over a single-port slot memory that also holds each slot's taken bit.
// After reset the memory is cleared one slot per cycle, all CAPACITY slots (1024
// by default), and no request is accepted until that pass ends. One transaction
// at a time; each probe step is a memory read followed by a compare/write. A
// lookup reads slots from the home slot on; placing a new key then walks on from
// where the lookup stopped to the free slot, and a removal reads on slot by slot
// while shifting the cluster back. A new response is held until taken before
// the next request.
module robin_hood_hash_table
   import rhht_pkg::*;
#(
   parameter int unsigned CAPACITY   = 1024,
   parameter int unsigned KEY_BITS   = 64,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   rhht_req_if.sink            req,
   rhht_rsp_if.source          rsp,
   input  logic                csr_write_enable,
   input  logic [FILL_W-1:0]   csr_write_data
);
   logic [FILL_W-1:0] max_fill_ff;
   dp_cmd_type        cmd;
   dp_status_type     stat;
   logic [SLOT_W-1:0] landed_slot;
   logic [VALUE_W-1:0] read_value;
   logic [COUNT_W-1:0] fill_count;

   always_ff @(posedge clock) begin
      if (reset) max_fill_ff <= FILL_RESET;
      else if (csr_write_enable) max_fill_ff <= csr_write_data;
   end

   rhht_controller u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
      .rsp_slot(rsp.slot), .rsp_value_out(rsp.value_out),
      .rsp_entry_count(rsp.entry_count),
      .cmd, .stat, .landed_slot, .read_value, .fill_count
   );

   rhht_datapath #(
      .CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock, .reset, .cmd,
      .req_key(req.key), .req_hash(req.key_hash), .req_value(req.value),
      .max_fill(max_fill_ff), .stat, .landed_slot, .read_value, .fill_count
   );
endmodule

>>> dv/robin_hood_hash_table_tb.sv
`timescale 1ns / 1ps

module robin_hood_hash_table_tb;
   import rhht_pkg::*;

   localparam int unsigned SLOTS = 1024;
   localparam int unsigned POOL  = 48;

   typedef struct {
      req_kind_type      kind;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] key_hash;
      logic [VALUE_W-1:0] value;
   } lookup_req_type;

   typedef struct {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0] entry_count;
   } lookup_rsp_type;

   logic clock;
   logic reset;
   logic              csr_write_enable;
   logic [FILL_W-1:0] csr_write_data;

   rhht_req_if req ();
   rhht_rsp_if rsp ();

   robin_hood_hash_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // shadow table
   logic [KEY_W-1:0]   tbl_key  [SLOTS];
   logic [VALUE_W-1:0] tbl_val  [SLOTS];
   int unsigned        tbl_dist [SLOTS];
   bit                 tbl_used [SLOTS];
   int unsigned        tbl_fill;
   int unsigned        fill_limit;

   lookup_req_type pending_reqs[$];
   lookup_rsp_type expected_rsps[$];
   int unsigned driven_cnt;
   int unsigned accepted_cnt;
   int unsigned error_cnt;
   int unsigned status_seen [6];
   bit          sender_hold;

   logic [KEY_W-1:0]  pool_key  [POOL];
   logic [HASH_W-1:0] pool_hash [POOL];

   function automatic bit find_slot(logic [KEY_W-1:0] k, int unsigned home,
                                    output int unsigned where);
      int unsigned s;
      int unsigned d;
      s = home;
      d = 0;
      where = 0;
      for (int unsigned n = 0; n < SLOTS; n++) begin
         if (!tbl_used[s]) return 1'b0;
         if (tbl_key[s] == k) begin
            where = s;
            return 1'b1;
         end
         if (tbl_dist[s] < d) return 1'b0;
         d++;
         s = (s + 1) % SLOTS;
      end
      return 1'b0;
   endfunction

   function automatic int unsigned place_key(logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                                             int unsigned home);
      int unsigned s;
      int unsigned d;
      int unsigned landed;
      int unsigned td;
      logic [KEY_W-1:0]   tk;
      logic [VALUE_W-1:0] tv;
      bit have;
      s = home;
      d = 0;
      landed = 0;
      have = 1'b0;
      for (int unsigned n = 0; n < SLOTS; n++) begin
         if (!tbl_used[s]) begin
            tbl_used[s] = 1'b1;
            tbl_key[s]  = k;
            tbl_val[s]  = v;
            tbl_dist[s] = d;
            tbl_fill++;
            if (!have) landed = s;
            break;
         end
         if (tbl_dist[s] < d) begin
            tk = tbl_key[s];
            tv = tbl_val[s];
            td = tbl_dist[s];
            tbl_key[s]  = k;
            tbl_val[s]  = v;
            tbl_dist[s] = d;
            k = tk;
            v = tv;
            d = td;
            if (!have) begin
               landed = s;
               have = 1'b1;
            end
         end
         d++;
         s = (s + 1) % SLOTS;
      end
      return landed;
   endfunction

   function automatic void erase_slot(int unsigned s);
      int unsigned prev;
      int unsigned cur;
      prev = s;
      cur = (s + 1) % SLOTS;
      tbl_used[s] = 1'b0;
      tbl_dist[s] = 0;
      if (tbl_fill > 0) tbl_fill--;
      for (int unsigned n = 1; n < SLOTS; n++) begin
         if (!tbl_used[cur] || tbl_dist[cur] == 0) break;
         tbl_key[prev]  = tbl_key[cur];
         tbl_val[prev]  = tbl_val[cur];
         tbl_dist[prev] = tbl_dist[cur] - 1;
         tbl_used[prev] = 1'b1;
         tbl_used[cur]  = 1'b0;
         prev = cur;
         cur = (cur + 1) % SLOTS;
      end
   endfunction

   function automatic lookup_rsp_type predict_lookup(lookup_req_type r);
      lookup_rsp_type o;
      int unsigned home;
      int unsigned s;
      bit hit;
      home = r.key_hash % SLOTS;
      o.status = ST_NOT_FOUND;
      o.slot = '0;
      o.value_out = '0;
      hit = find_slot(r.key, home, s);
      case (r.kind)
         REQ_INSERT: begin
            if (hit) begin
               tbl_val[s] = r.value;
               o.status = ST_UPDATED;
               o.slot = s[SLOT_W-1:0];
            end else if (tbl_fill >= fill_limit || tbl_fill >= SLOTS) begin
               o.status = ST_FULL;
            end else begin
               s = place_key(r.key, r.value, home);
               o.status = ST_INSERTED;
               o.slot = s[SLOT_W-1:0];
            end
         end
         REQ_FIND: begin
            if (hit) begin
               o.status = ST_FOUND;
               o.slot = s[SLOT_W-1:0];
               o.value_out = tbl_val[s];
            end
         end
         REQ_REMOVE: begin
            if (hit) begin
               erase_slot(s);
               o.status = ST_REMOVED;
            end
         end
         default: ;
      endcase
      o.entry_count = tbl_fill[COUNT_W-1:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_cnt++;
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      lookup_rsp_type want;
      lookup_req_type got_req;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", rsp.status, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp.status != want.status)
                  report_mismatch("status", rsp.status, want.status);
               if (rsp.slot != want.slot)
                  report_mismatch("slot", rsp.slot, want.slot);
               if (rsp.value_out != want.value_out)
                  report_mismatch("value_out", rsp.value_out, want.value_out);
               if (rsp.entry_count != want.entry_count)
                  report_mismatch("entry_count", rsp.entry_count, want.entry_count);
               if (rsp.status < 6) status_seen[rsp.status]++;
            end
         end
         if (req.valid && req.ready) begin
            got_req.kind = req_kind_type'(req.req_type);
            got_req.key = req.key;
            got_req.key_hash = req.key_hash;
            got_req.value = req.value;
            expected_rsps.push_back(predict_lookup(got_req));
            accepted_cnt++;
         end
      end
   end

   // driver
   int unsigned burst_left;
   int unsigned gap_left;
   always @(negedge clock) begin
      lookup_req_type nxt;
      if (!reset) begin
         if (driven_cnt != accepted_cnt) begin
            // hold
         end else if (gap_left > 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !sender_hold) begin
            nxt = pending_reqs.pop_front();
            req.req_type <= nxt.kind;
            req.key      <= nxt.key;
            req.key_hash <= nxt.key_hash;
            req.value    <= nxt.value;
            req.valid    <= 1'b1;
            driven_cnt++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   int unsigned stall_mode;
   int unsigned stall_left;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= $urandom_range(0, 1);
         default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic push_req(req_kind_type kind, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                           logic [VALUE_W-1:0] v);
      lookup_req_type r;
      r.kind = kind;
      r.key = k;
      r.key_hash = h;
      r.value = v;
      pending_reqs.push_back(r);
   endtask

   task automatic drain;
      wait (pending_reqs.size() == 0 && driven_cnt == accepted_cnt && expected_rsps.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_fill_limit(logic [FILL_W-1:0] lim);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= lim;
      fill_limit = lim;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_random(int unsigned count, int unsigned noise_pct);
      int unsigned sel;
      int unsigned pick;
      int unsigned roll;
      req_kind_type kind;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) kind = REQ_INSERT;
         else if (roll < 75) kind = REQ_FIND;
         else if (roll < 95) kind = REQ_REMOVE;
         else kind = REQ_NONE;
         sel = $urandom_range(0, POOL - 1);
         pick = $urandom_range(0, 99);
         if (pick < noise_pct)
            push_req(kind, rand64(), $urandom, rand64());
         else if (pick < noise_pct + 3)
            push_req(kind, pool_key[sel], $urandom, rand64());
         else
            push_req(kind, pool_key[sel], pool_hash[sel], rand64());
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.req_type = REQ_NONE;
      req.key = '0;
      req.key_hash = '0;
      req.value = '0;
      rsp.ready = 1'b0;
      driven_cnt = 0;
      accepted_cnt = 0;
      error_cnt = 0;
      burst_left = 0;
      gap_left = 0;
      stall_left = 0;
      sender_hold = 1'b0;
      tbl_fill = 0;
      fill_limit = FILL_RESET;
      foreach (tbl_used[i]) begin
         tbl_used[i] = 1'b0;
         tbl_dist[i] = 0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      for (int unsigned i = 0; i < POOL; i++) begin
         pool_key[i] = rand64();
         pool_hash[i] = {22'($urandom_range(0, 32'h3F_FFFF)), 10'((i % 12 + 1018) % SLOTS)};
      end
      pool_key[0] = '0;
      pool_key[1] = '1;
      pool_hash[1] = '1;
      pool_hash[2] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      push_req(REQ_FIND, pool_key[0], pool_hash[0], '0);
      push_req(REQ_REMOVE, pool_key[0], pool_hash[0], '0);
      push_req(REQ_INSERT, pool_key[0], pool_hash[0], '1);
      push_req(REQ_INSERT, pool_key[1], pool_hash[1], '0);
      push_req(REQ_INSERT, pool_key[2], pool_hash[2], 64'h0123_4567_89AB_CDEF);
      for (int unsigned i = 3; i < 10; i++)
         push_req(REQ_INSERT, pool_key[i], pool_hash[i], rand64());
      push_req(REQ_INSERT, pool_key[1], pool_hash[1], '1);
      push_req(REQ_FIND, pool_key[1], pool_hash[1], '0);
      push_req(REQ_FIND, pool_key[0], pool_hash[0], '0);
      push_req(REQ_FIND, pool_key[20], pool_hash[20], '0);
      push_req(REQ_REMOVE, pool_key[20], pool_hash[20], '0);
      push_req(REQ_NONE, pool_key[1], pool_hash[1], '1);
      push_req(REQ_REMOVE, pool_key[3], pool_hash[3], '0);
      push_req(REQ_FIND, pool_key[4], pool_hash[4], '0);
      push_req(REQ_REMOVE, pool_key[1], pool_hash[1], '0);
      push_req(REQ_FIND, pool_key[2], pool_hash[2], '0);
      set_fill_limit(10'd0);
      push_req(REQ_INSERT, pool_key[30], pool_hash[30], rand64());
      push_req(REQ_INSERT, pool_key[2], pool_hash[2], rand64());
      set_fill_limit(10'd1);
      push_random(60, 0);
      set_fill_limit(10'd8);
      push_random(200, 0);
      // pause until every expected transaction has returned
      wait (pending_reqs.size() == 0);
      sender_hold = 1'b1;
      wait (driven_cnt == accepted_cnt && expected_rsps.size() == 0);
      push_random(100, 0);
      sender_hold = 1'b0;
      set_fill_limit(10'd1023);
      push_random(300, 8);
      set_fill_limit(10'd20);
      push_random(240, 2);
      drain();
      $display("covered %0d transactions: inserted %0d updated %0d found %0d",
               accepted_cnt, status_seen[ST_INSERTED], status_seen[ST_UPDATED],
               status_seen[ST_FOUND]);
      $display("not found %0d removed %0d rejected full %0d, final fill %0d",
               status_seen[ST_NOT_FOUND], status_seen[ST_REMOVED], status_seen[ST_FULL],
               tbl_fill);
      if (error_cnt == 0 && expected_rsps.size() == 0) begin
         $display("robin_hood_hash_table_tb OK");
      end else begin
         $display("robin_hood_hash_table_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout waiting for transactions");
      $display("robin_hood_hash_table_tb NOT OK");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/rhht_pkg.sv
rtl/core/rhht_req_if.sv
rtl/core/rhht_rsp_if.sv
rtl/core/rhht_datapath.sv
rtl/core/rhht_controller.sv
rtl/core/robin_hood_hash_table.sv
dv/robin_hood_hash_table_tb.sv
